// ===== design/tmcw_pkg.sv =====
// shared types, constants and codes of the text mode console writer
package tmcw_pkg;

   localparam int SCREEN_COLS = 80;
   localparam int SCREEN_ROWS = 25;
   localparam int TAB_STOP    = 8;
   localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLS;

   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = $clog2(CELL_COUNT);

   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [ADDR_W-1:0] addr_type;

   localparam row_type  ROW_LAST   = ROW_W'(SCREEN_ROWS - 1);
   localparam col_type  COL_LAST   = COL_W'(SCREEN_COLS - 1);
   localparam char_type SPACE_CHAR = 8'h20;
   localparam char_type BYTE_CR    = 8'h0D;
   localparam char_type BYTE_LF    = 8'h0A;
   localparam char_type BYTE_BS    = 8'h08;
   localparam char_type BYTE_TAB   = 8'h09;
   localparam char_type BYTE_CLEAR = 8'h1A;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_READ  = 1'b1;

   typedef enum logic [2:0] {
      BC_CR, BC_LF, BC_BS, BC_TAB, BC_CLEAR, BC_CHAR
   } byte_class_type;

   typedef enum logic [2:0] {
      CUR_HOLD, CUR_CR, CUR_BS, CUR_LF, CUR_ADV, CUR_HOME
   } cur_op_type;

   typedef enum logic [2:0] {
      MEM_NONE, MEM_READ, MEM_STORE, MEM_CLEAR, MEM_BLANK
   } mem_op_type;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_EXEC, ST_TAB, ST_CLEAR, ST_BLANK, ST_RESP
   } state_type;

   typedef struct packed {
      logic       load_item;
      logic       rsp_load;
      logic       store_space;
      cur_op_type cur_op;
      mem_op_type mem_op;
   } cmd_type;

   typedef struct packed {
      logic           kind;
      byte_class_type byte_class;
      logic           col_aligned;
      logic           adv_aligned;
      logic           adv_scroll;
      logic           lf_scroll;
      logic           clear_last;
      logic           blank_last;
      logic           rsp_free;
   } status_type;

endpackage

// ===== design/tmcw_ram.sv =====
// generic single write port, single read port ram with registered read
module tmcw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tmcw_ctrl.sv =====
// sequencing state machine of the text mode console writer
module tmcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   input  tmcw_pkg::status_type status,
   output tmcw_pkg::cmd_type    cmd,
   output logic                idle
);
   import tmcw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd.load_item   = 1'b0;
      cmd.rsp_load    = 1'b0;
      cmd.store_space = 1'b0;
      cmd.cur_op      = CUR_HOLD;
      cmd.mem_op      = MEM_NONE;
      idle            = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.mem_op = MEM_CLEAR;
            if (status.clear_last) begin
               cmd.cur_op = CUR_HOME;
               state_in   = ST_IDLE;
            end
         end
         ST_IDLE: begin
            idle = 1'b1;
            if (req_fire) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.kind == KIND_READ) begin
               cmd.mem_op = MEM_READ;
               state_in   = ST_RESP;
            end else begin
               unique case (status.byte_class)
                  BC_CR: begin
                     cmd.cur_op = CUR_CR;
                     state_in   = ST_RESP;
                  end
                  BC_BS: begin
                     cmd.cur_op = CUR_BS;
                     state_in   = ST_RESP;
                  end
                  BC_LF: begin
                     cmd.cur_op = CUR_LF;
                     state_in   = status.lf_scroll ? ST_BLANK : ST_RESP;
                  end
                  BC_TAB: begin
                     state_in = status.col_aligned ? ST_RESP : ST_TAB;
                  end
                  BC_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     cmd.mem_op = MEM_STORE;
                     cmd.cur_op = CUR_ADV;
                     state_in   = status.adv_scroll ? ST_BLANK : ST_RESP;
                  end
               endcase
            end
         end
         ST_TAB: begin
            // one padding space per cycle, a line wrap ends the tab
            cmd.mem_op      = MEM_STORE;
            cmd.store_space = 1'b1;
            cmd.cur_op      = CUR_ADV;
            if (status.adv_aligned) begin
               state_in = status.adv_scroll ? ST_BLANK : ST_RESP;
            end
         end
         ST_CLEAR: begin
            cmd.mem_op = MEM_CLEAR;
            if (status.clear_last) begin
               cmd.cur_op = CUR_HOME;
               state_in   = ST_RESP;
            end
         end
         ST_BLANK: begin
            cmd.mem_op = MEM_BLANK;
            if (status.blank_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

endmodule

// ===== design/tmcw_dp.sv =====
// cursor, scroll offset, screen store and result register of the console writer
module tmcw_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tmcw_pkg::cmd_type    cmd,
   output tmcw_pkg::status_type status,
   input  logic                 req_kind,
   input  tmcw_pkg::char_type   req_byte_value,
   input  tmcw_pkg::row_type    req_read_row,
   input  tmcw_pkg::col_type    req_read_col,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tmcw_pkg::char_type   rsp_cell_char,
   output tmcw_pkg::row_type    rsp_cursor_row,
   output tmcw_pkg::col_type    rsp_cursor_col
);
   import tmcw_pkg::*;

   // cursor and physical row that shows as logical row 0
   row_type  row_ff, row_in;
   col_type  col_ff, col_in;
   row_type  top_ff, top_in;
   addr_type sweep_ff, sweep_in;

   logic     kind_ff;
   char_type byte_ff;
   row_type  read_row_ff;
   col_type  read_col_ff;

   logic     rsp_valid_ff, rsp_valid_in;
   char_type rsp_cell_ff;
   row_type  rsp_row_ff;
   col_type  rsp_col_ff;

   col_type  col_inc;
   logic     read_hit;
   logic     wr_en;
   addr_type wr_addr;
   char_type wr_data;
   logic     rd_en;
   char_type rd_data;

   function automatic addr_type cell_addr(row_type r, col_type c, row_type top);
      logic [ROW_W:0] sum;
      logic [ROW_W:0] prow;
      sum  = {1'b0, r} + {1'b0, top};
      prow = (sum >= (ROW_W+1)'(SCREEN_ROWS)) ? sum - (ROW_W+1)'(SCREEN_ROWS) : sum;
      return ADDR_W'(prow) * ADDR_W'(SCREEN_COLS) + ADDR_W'(c);
   endfunction

   function automatic byte_class_type classify(char_type b);
      byte_class_type bc;
      unique case (b)
         BYTE_CR:    bc = BC_CR;
         BYTE_LF:    bc = BC_LF;
         BYTE_BS:    bc = BC_BS;
         BYTE_TAB:   bc = BC_TAB;
         BYTE_CLEAR: bc = BC_CLEAR;
         default:    bc = BC_CHAR;
      endcase
      return bc;
   endfunction

   assign col_inc  = col_ff + COL_W'(1);
   assign read_hit = (read_row_ff < ROW_W'(SCREEN_ROWS)) &&
                     (read_col_ff < COL_W'(SCREEN_COLS));

   assign status.kind        = kind_ff;
   assign status.byte_class  = classify(byte_ff);
   assign status.col_aligned = (col_ff % TAB_STOP) == 0;
   assign status.adv_aligned = ((col_inc % TAB_STOP) == 0) || (col_ff == COL_LAST);
   assign status.adv_scroll  = (col_ff == COL_LAST) && (row_ff == ROW_LAST);
   assign status.lf_scroll   = row_ff == ROW_LAST;
   assign status.clear_last  = sweep_ff == ADDR_W'(CELL_COUNT - 1);
   assign status.blank_last  = sweep_ff == ADDR_W'(SCREEN_COLS - 1);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

   // cursor update, scrolling rotates the top row pointer
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      top_in = top_ff;
      unique case (cmd.cur_op)
         CUR_CR: begin
            col_in = '0;
         end
         CUR_BS: begin
            if (col_ff != '0) begin
               col_in = col_ff - COL_W'(1);
            end
         end
         CUR_LF, CUR_ADV: begin
            if (cmd.cur_op == CUR_ADV && col_ff != COL_LAST) begin
               col_in = col_inc;
            end else begin
               if (cmd.cur_op == CUR_ADV) begin
                  col_in = '0;
               end
               if (row_ff == ROW_LAST) begin
                  top_in = (top_ff == ROW_LAST) ? '0 : top_ff + ROW_W'(1);
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end
         end
         CUR_HOME: begin
            row_in = '0;
            col_in = '0;
            top_in = '0;
         end
         default: begin
         end
      endcase
   end

   // screen store port selection and sweep counter
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cell_addr(row_ff, col_ff, top_ff);
      wr_data  = cmd.store_space ? SPACE_CHAR : byte_ff;
      rd_en    = 1'b0;
      sweep_in = sweep_ff;
      unique case (cmd.mem_op)
         MEM_READ: begin
            rd_en = read_hit;
         end
         MEM_STORE: begin
            wr_en = 1'b1;
         end
         MEM_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = SPACE_CHAR;
            sweep_in = status.clear_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         MEM_BLANK: begin
            wr_en    = 1'b1;
            wr_addr  = cell_addr(ROW_LAST, sweep_ff[COL_W-1:0], top_ff);
            wr_data  = SPACE_CHAR;
            sweep_in = status.blank_last ? '0 : sweep_ff + ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff     <= req_kind;
         byte_ff     <= req_byte_value;
         read_row_ff <= req_read_row;
         read_col_ff <= req_read_col;
      end
      if (cmd.rsp_load) begin
         rsp_cell_ff <= (kind_ff == KIND_READ && read_hit) ? rd_data : '0;
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
      end
   end

   tmcw_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(CELL_COUNT)
   ) u_screen (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(cell_addr(read_row_ff, read_col_ff, top_ff)),
      .rd_data(rd_data)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_cell_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;

endmodule

// ===== design/text_mode_console_writer.sv =====
// top level of the text mode console writer: 25 x 80 character screen with cursor
// sequence: a transfer is taken in idle, the item is executed, then its result is loaded into the
//   result register that drives rsp_tvalid; a tab first stores padding spaces, a scroll blanks the
//   80 cells of the new bottom row and a clear all 2000 cells, one cell per cycle
// one item at a time: a new item is taken only after the last one has loaded its result
// reset: synchronous; a clearing pass then fills all 2000 cells with spaces, req_tready low
module text_mode_console_writer (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // byte_value[7:0], read_row[12:8], read_col[19:13]
   input  logic        req_tuser,  // kind: 0 write byte, 1 read cell
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // cell_char[7:0], cursor_row[12:8], cursor_col[19:13]
);
   import tmcw_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       idle;
   logic       req_fire;
   char_type   cell_char;
   row_type    cursor_row;
   col_type    cursor_col;

   // one item taken per transfer while the controller sits idle
   assign req_tready = idle;
   assign req_fire   = req_tvalid && idle;

   tmcw_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .req_fire(req_fire),
      .status  (status),
      .cmd     (cmd),
      .idle    (idle)
   );

   // the result register in the datapath lets the next item enter while a result waits
   tmcw_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_kind      (req_tuser),
      .req_byte_value(req_tdata[7:0]),
      .req_read_row  (req_tdata[12:8]),
      .req_read_col  (req_tdata[19:13]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_cell_char (cell_char),
      .rsp_cursor_row(cursor_row),
      .rsp_cursor_col(cursor_col)
   );

   // pad to whole bytes with zeros
   assign rsp_tdata = {4'b0000, cursor_col, cursor_row, cell_char};

endmodule
